>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel rotate/convert design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define PRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property that must hold on the edge right after a reset cycle.
`define PRC_ASSERT_AFTER_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) (!rstn) |=> (prop)) else $error(msg);

`endif

>>> design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and the pixel format function.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int MAX_DIM_DEF  = 4096;
  localparam int REG_W        = 13;
  localparam int ROT_W        = 2;
  localparam int ADDR_W       = 24;
  localparam int PIX_W        = 32;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hFF000000;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] source_width;
    logic [REG_W-1:0] source_height;
    logic [ROT_W-1:0] rotation_mode;
    logic             ten_bit_mode;
    logic [REG_W-1:0] dest_stride;
  } cfg_t;

  // A2B10G10R10 to BGRA8: top 8 bits of each color channel, alpha opaque.
  function automatic logic [PIX_W-1:0] to_bgra8(input logic [PIX_W-1:0] v);
    return ALPHA_OPAQUE | {8'h00, v[9:2], v[19:12], v[29:22]};
  endfunction

endpackage

`default_nettype wire

>>> design/prc_cfg_regs.sv
// ----------------------------------------------------------------------------
// prc_cfg_regs
// APB-style register file holding frame size, rotation, format and stride.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_cfg_regs
  import prc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output cfg_t                       cfg
);

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROTATION   = 3'd2;
  localparam logic [2:0] REG_TEN_BIT    = 3'd3;
  localparam logic [2:0] REG_STRIDE     = 3'd4;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= REG_W'(1);
      cfg_r.source_height <= REG_W'(1);
      cfg_r.rotation_mode <= ROT_0;
      cfg_r.ten_bit_mode  <= 1'b0;
      cfg_r.dest_stride   <= REG_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_WIDTH:  cfg_r.source_width  <= pwdata[REG_W-1:0];
        REG_SRC_HEIGHT: cfg_r.source_height <= pwdata[REG_W-1:0];
        REG_ROTATION:   cfg_r.rotation_mode <= pwdata[ROT_W-1:0];
        REG_TEN_BIT:    cfg_r.ten_bit_mode  <= pwdata[0];
        REG_STRIDE:     cfg_r.dest_stride   <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:  prdata = CFG_DATA_W'(cfg_r.source_width);
      REG_SRC_HEIGHT: prdata = CFG_DATA_W'(cfg_r.source_height);
      REG_ROTATION:   prdata = CFG_DATA_W'(cfg_r.rotation_mode);
      REG_TEN_BIT:    prdata = CFG_DATA_W'(cfg_r.ten_bit_mode);
      REG_STRIDE:     prdata = CFG_DATA_W'(cfg_r.dest_stride);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/prc_coord_gen.sv
// ----------------------------------------------------------------------------
// prc_coord_gen
// Raster column/row counters with size clamping and coordinate rotation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module prc_coord_gen
  import prc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int CNT_W   = $clog2(MAX_DIM)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             advance,
  output logic      [CNT_W-1:0] dest_col,
  output logic      [CNT_W-1:0] dest_row,
  output logic                  frame_end
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > REG_W) ? DIM_W : REG_W;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w, h;
  logic [CNT_W-1:0] wm1, hm1;
  logic [CNT_W-1:0] x, y;
  logic             last_col, last_row;

  // Sizes of zero count as one, sizes beyond the maximum as the maximum.
  always_comb begin
    if (cfg.source_width == '0) begin
      w = DIM_W'(1);
    end else if (CMP_W'(cfg.source_width) > MAX_DIM_C) begin
      w = DIM_W'(MAX_DIM);
    end else begin
      w = DIM_W'(CMP_W'(cfg.source_width));
    end
    if (cfg.source_height == '0) begin
      h = DIM_W'(1);
    end else if (CMP_W'(cfg.source_height) > MAX_DIM_C) begin
      h = DIM_W'(MAX_DIM);
    end else begin
      h = DIM_W'(CMP_W'(cfg.source_height));
    end
  end

  assign wm1 = CNT_W'(w - DIM_W'(1));
  assign hm1 = CNT_W'(h - DIM_W'(1));

  // A counter left beyond a shrunken size acts as the last column or row.
  assign x        = (DIM_W'(col_r) < w) ? col_r : wm1;
  assign y        = (DIM_W'(row_r) < h) ? row_r : hm1;
  assign last_col = (x == wm1);
  assign last_row = (y == hm1);
  assign frame_end = last_col && last_row;

  always_comb begin
    case (cfg.rotation_mode)
      ROT_90: begin
        dest_col = hm1 - y;
        dest_row = x;
      end
      ROT_180: begin
        dest_col = wm1 - x;
        dest_row = hm1 - y;
      end
      ROT_270: begin
        dest_col = y;
        dest_row = wm1 - x;
      end
      default: begin
        dest_col = x;
        dest_row = y;
      end
    endcase
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : y + CNT_W'(1);
      end else begin
        col_nxt = x + CNT_W'(1);
        row_nxt = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `PRC_ASSERT(a_frame_wrap, clk, rst_n, (advance && frame_end) |=> (col_r == '0 && row_r == '0), "counters did not wrap after the last pixel")
  `PRC_ASSERT(a_col_step, clk, rst_n, (advance && !last_col) |=> (col_r == $past(x) + CNT_W'(1) && row_r == $past(y)), "column did not step within a row")
  `PRC_ASSERT(a_hold, clk, rst_n, !advance |=> ($stable(col_r) && $stable(row_r)), "counters moved without an accepted item")

endmodule

`default_nettype wire

>>> design/prc_addr_calc.sv
// ----------------------------------------------------------------------------
// prc_addr_calc
// Destination address (row * stride + column) and pixel format conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_addr_calc
  import prc_pkg::*;
#(
  parameter int CNT_W = $clog2(MAX_DIM_DEF)
) (
  input  wire logic [CNT_W-1:0]  dest_col,
  input  wire logic [CNT_W-1:0]  dest_row,
  input  wire logic [REG_W-1:0]  dest_stride,
  input  wire logic              ten_bit_mode,
  input  wire logic [PIX_W-1:0]  source_pixel,
  output logic      [ADDR_W-1:0] dest_address,
  output logic      [PIX_W-1:0]  dest_pixel
);

  localparam int SUM_W = CNT_W + REG_W + 1;

  logic [SUM_W-1:0] sum;

  // The address wraps modulo 2^24.
  assign sum = SUM_W'(dest_row) * SUM_W'(dest_stride) + SUM_W'(dest_col);
  assign dest_address = ADDR_W'(sum);
  assign dest_pixel   = ten_bit_mode ? to_bgra8(source_pixel) : source_pixel;

endmodule

`default_nettype wire

>>> design/pixel_rotate_format_convert_unit.sv
// ----------------------------------------------------------------------------
// pixel_rotate_format_convert_unit
// Rotates raster pixel coordinates into destination addresses and converts
// A2B10G10R10 pixels to BGRA8.
// ----------------------------------------------------------------------------
// Usage:
// Source pixels arrive in raster order on the in_ stream, one 32-bit pixel per
// item. For every item the out_ stream delivers one item carrying the rotated
// destination address (row times stride plus column) and the converted or
// passed-through pixel; tlast marks the last pixel of the frame.
// Frame size, rotation, pixel format and stride are set over the cfg_ APB port
// while the block is idle; cfg_pready is always high.
// An accepted item is registered in the first stage and then in the second
// stage, from which it is offered on the out_ stream.
// Throughput is one item per clock while the receiver does not stall: the
// first stage registers the rotated coordinate and the pixel, the second
// stage holds the result after one multiply and add. The stride multiply in
// the second stage sets the clock path.
// Reset (synchronous, active low) empties both stages, returns the counters
// to the first pixel of a frame and loads width 1, height 1, no rotation,
// pass-through and stride 1. When the receiver stalls, the result holds and
// the block still takes one more item into its first stage; after that
// in_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pixel_rotate_format_convert_unit
  import prc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream. in_tdata: source_pixel[31:0].
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,
  // Result stream. out_tdata: dest_address[23:0], dest_pixel[55:24].
  // out_tlast: frame_end.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [ADDR_W+PIX_W-1:0]    out_tdata,
  output logic                       out_tlast,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CNT_W = $clog2(MAX_DIM);

  cfg_t cfg;

  logic             in_acc;
  logic             adv2;
  logic [CNT_W-1:0] gen_col, gen_row;
  logic             gen_last;

  // First stage: rotated coordinate and raw pixel.
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CNT_W-1:0] s1_col_r, s1_row_r;
  logic             s1_last_r;

  // Second stage: the result item.
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [PIX_W-1:0]  out_pix_r, out_pix_nxt;
  logic              out_last_r;

  assign cfg_pready = 1'b1;

  prc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite && cfg_pready),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The second stage moves whenever it is empty or its item is taken.
  assign adv2      = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv2;
  assign in_acc    = in_tvalid && in_tready;

  prc_coord_gen #(
    .MAX_DIM (MAX_DIM),
    .CNT_W   (CNT_W)
  ) u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (in_acc),
    .dest_col  (gen_col),
    .dest_row  (gen_row),
    .frame_end (gen_last)
  );

  prc_addr_calc #(
    .CNT_W (CNT_W)
  ) u_addr (
    .dest_col     (s1_col_r),
    .dest_row     (s1_row_r),
    .dest_stride  (cfg.dest_stride),
    .ten_bit_mode (cfg.ten_bit_mode),
    .source_pixel (s1_pix_r),
    .dest_address (out_addr_nxt),
    .dest_pixel   (out_pix_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv2) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv2 ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_tdata;
      s1_col_r  <= gen_col;
      s1_row_r  <= gen_row;
      s1_last_r <= gen_last;
    end
    if (adv2 && s1_valid_r) begin
      out_addr_r <= out_addr_nxt;
      out_pix_r  <= out_pix_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r, out_addr_r};
  assign out_tlast  = out_last_r;

  `PRC_ASSERT_AFTER_RST(a_rst_empty, clk, rst_n, (!out_tvalid && in_tready), "pipeline not empty after reset")
  `PRC_ASSERT(a_in_stall, clk, rst_n, !in_tready |-> (s1_valid_r && out_tvalid && !out_tready), "input stalled while the pipeline had room")
  `PRC_ASSERT(a_drain, clk, rst_n, (out_tvalid && out_tready && !s1_valid_r) |=> !out_tvalid, "result repeated after it was taken")

endmodule

`default_nettype wire
